FILE: rtl/core/c39enc_pkg.sv
`timescale 1ns / 1ps

package c39enc_pkg;

    // Result kinds as carried on the pattern_kind field
    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    localparam int unsigned SYMBOL_COUNT = 43;
    localparam int unsigned ELEMENTS     = 9;
    localparam int unsigned MODULE_BITS  = 16;

    localparam logic [1:0] WIDE_RATIO_RESET = 2'd3;

    // Bit (8 - i) set when element i is wide
    localparam logic [8:0] START_STOP_MASK = 9'h094;

    localparam logic [8:0] WIDE_MASK [0:SYMBOL_COUNT-1] = '{
        9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
        9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
        9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
        9'h085, 9'h184, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A, 9'h0C4
    };

    // Character lookup result
    typedef struct packed {
        logic       valid;
        logic [8:0] wide_mask;
    } lookup_t;

    // One pattern to render
    typedef struct packed {
        logic [8:0] wide_mask;
        logic       gap;
        logic       wide_three;   // wide element spans 3 modules, else 2
    } expand_req_t;

    typedef struct packed {
        logic [MODULE_BITS-1:0] modules;
        logic [4:0]             count;
    } pattern_t;

endpackage

FILE: rtl/core/c39enc_lookup.sv
`timescale 1ns / 1ps

module c39enc_lookup
    import c39enc_pkg::*;
(
    input  logic [7:0] char_code,
    output lookup_t    result
);

    logic [5:0] sym_idx;
    logic       sym_ok;

    // Case-folded character to symbol index
    always_comb begin
        sym_idx = '0;
        sym_ok  = 1'b1;
        if (char_code >= 8'h30 && char_code <= 8'h39) begin
            sym_idx = 6'(char_code - 8'h30);
        end else if (char_code >= 8'h61 && char_code <= 8'h7A) begin
            sym_idx = 6'(char_code - 8'h61) + 6'd10;
        end else if (char_code >= 8'h41 && char_code <= 8'h5A) begin
            sym_idx = 6'(char_code - 8'h41) + 6'd10;
        end else begin
            unique case (char_code)
                8'h2D:   sym_idx = 6'd36;   // '-'
                8'h2E:   sym_idx = 6'd37;   // '.'
                8'h24:   sym_idx = 6'd38;   // '$'
                8'h2F:   sym_idx = 6'd39;   // '/'
                8'h2B:   sym_idx = 6'd40;   // '+'
                8'h25:   sym_idx = 6'd41;   // '%'
                8'h20:   sym_idx = 6'd42;   // space
                default: sym_ok  = 1'b0;
            endcase
        end
    end

    assign result.valid     = sym_ok;
    assign result.wide_mask = sym_ok ? WIDE_MASK[sym_idx] : '0;

endmodule

FILE: rtl/core/c39enc_expand.sv
`timescale 1ns / 1ps

module c39enc_expand
    import c39enc_pkg::*;
(
    input  expand_req_t req,
    output pattern_t    pattern
);

    logic [4:0] pos  [0:ELEMENTS-1];
    logic [1:0] span [0:ELEMENTS-1];
    logic [3:0] wide_seen;
    logic [4:0] wide_mods;
    logic [5:0] total;
    logic [5:0] pos_end;
    logic [MODULE_BITS-1:0] bits;

    // Element start positions from a running count of wide elements
    always_comb begin
        wide_seen = '0;
        for (int i = 0; i < ELEMENTS; i++) begin
            wide_mods = req.wide_three ? {wide_seen, 1'b0} : {1'b0, wide_seen};
            pos[i]    = 5'(i) + wide_mods;
            span[i]   = req.wide_mask[ELEMENTS-1-i] ? (req.wide_three ? 2'd3 : 2'd2) : 2'd1;
            wide_seen = wide_seen + 4'(req.wide_mask[ELEMENTS-1-i]);
        end
        wide_mods = req.wide_three ? {wide_seen, 1'b0} : {1'b0, wide_seen};
        total     = 6'(ELEMENTS) + {1'b0, wide_mods} + 6'(req.gap);
    end

    // Bars sit on even elements; first module lands in the MSB
    always_comb begin
        bits    = '0;
        pos_end = '0;
        for (int p = 0; p < MODULE_BITS; p++) begin
            for (int i = 0; i < ELEMENTS; i += 2) begin
                pos_end = {1'b0, pos[i]} + 6'(span[i]);
                if (5'(p) >= pos[i] && 6'(p) < pos_end) begin
                    bits[MODULE_BITS-1-p] = 1'b1;
                end
            end
        end
    end

    assign pattern.modules = bits;
    assign pattern.count   = 5'(total);

endmodule

FILE: rtl/core/code39_module_encoder.sv
`timescale 1ns / 1ps

// Code 39 module encoder.
// Input channel (s_*): one ASCII character per request, case folded, with an
// end-of-message flag. Output channel (m_*): one rendered pattern per request,
// up to 16 modules left-aligned in m_modules (bar = 1), its length, its kind
// (start, data, stop) and a last flag on the final pattern of an input.
// The first character of a message is preceded by the start pattern; a
// flagged character is followed by the stop pattern. Unknown characters
// give no data pattern. cfg_wr_en/cfg_wr_data set the wide-element ratio
// (values below 2 act as 2); write it only while the block is idle.
// An accepted input is held in the pending-pattern stage; its patterns then
// move one by one to the output register (start, data, stop in that order).
// Throughput: one result per cycle while the output is not stalled, set by the
// single result register; a character may give up to three patterns in turn.
// An input is taken while the previous one's last pattern moves to the
// output register, so requests flow back to back while the output drains.
// When m_ready is low the output and the pending patterns hold and s_ready
// drops once the pending item cannot drain. Reset (aresetn low, synchronous)
// empties both stages, closes any open message and sets the ratio to 3.

module code39_module_encoder
    import c39enc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_char_code,
    input  logic        s_end_of_message,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_modules,
    output logic [4:0]  m_module_count,
    output logic [1:0]  m_pattern_kind,
    output logic        m_last
);

    logic [1:0] wide_ratio_reg;
    logic       in_message_reg, in_message_next;

    // Pending patterns for the held request
    logic       st_start_reg, st_start_next;
    logic       st_data_reg,  st_data_next;
    logic       st_stop_reg,  st_stop_next;
    logic [8:0] st_mask_reg,  st_mask_next;

    logic              m_valid_reg, m_valid_next;
    logic [15:0]       m_modules_reg;
    logic [4:0]        m_count_reg;
    kind_t             m_kind_reg;
    logic              m_last_reg;

    lookup_t     lk;
    expand_req_t ex_req;
    pattern_t    ex_pat;

    logic  st_any, out_free, emit, emit_last, accept;
    kind_t emit_kind;

    c39enc_lookup u_lookup (
        .char_code (s_char_code),
        .result    (lk)
    );

    c39enc_expand u_expand (
        .req     (ex_req),
        .pattern (ex_pat)
    );

    assign st_any   = st_start_reg | st_data_reg | st_stop_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign emit     = st_any && out_free;

    // Start first, then the data symbol, then stop
    always_comb begin
        if (st_start_reg) begin
            emit_kind = KIND_START;
            emit_last = !(st_data_reg || st_stop_reg);
        end else if (st_data_reg) begin
            emit_kind = KIND_DATA;
            emit_last = !st_stop_reg;
        end else begin
            emit_kind = KIND_STOP;
            emit_last = 1'b1;
        end
    end

    assign ex_req.wide_mask  = (emit_kind == KIND_DATA) ? st_mask_reg : START_STOP_MASK;
    assign ex_req.gap        = (emit_kind != KIND_STOP);
    assign ex_req.wide_three = (wide_ratio_reg == 2'd3);

    // Take a new request when the stage is empty or draining its last pattern
    assign s_ready = !st_any || (emit && emit_last);
    assign accept  = s_valid && s_ready;

    always_comb begin
        st_start_next   = st_start_reg;
        st_data_next    = st_data_reg;
        st_stop_next    = st_stop_reg;
        st_mask_next    = st_mask_reg;
        in_message_next = in_message_reg;
        if (emit) begin
            case (emit_kind)
                KIND_START: st_start_next = 1'b0;
                KIND_DATA:  st_data_next  = 1'b0;
                default:    st_stop_next  = 1'b0;
            endcase
        end
        if (accept) begin
            st_start_next   = !in_message_reg;
            st_data_next    = lk.valid;
            st_stop_next    = s_end_of_message;
            st_mask_next    = lk.wide_mask;
            in_message_next = !s_end_of_message;
        end
    end

    assign m_valid_next = emit || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_ratio_reg <= WIDE_RATIO_RESET;
            in_message_reg <= 1'b0;
            st_start_reg   <= 1'b0;
            st_data_reg    <= 1'b0;
            st_stop_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                wide_ratio_reg <= cfg_wr_data;
            end
            in_message_reg <= in_message_next;
            st_start_reg   <= st_start_next;
            st_data_reg    <= st_data_next;
            st_stop_reg    <= st_stop_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        st_mask_reg <= st_mask_next;
        if (emit) begin
            m_modules_reg <= ex_pat.modules;
            m_count_reg   <= ex_pat.count;
            m_kind_reg    <= emit_kind;
            m_last_reg    <= emit_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_modules      = m_modules_reg;
    assign m_module_count = m_count_reg;
    assign m_pattern_kind = m_kind_reg;
    assign m_last         = m_last_reg;

    // A flagged request always leaves the message closed
    a_eom_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_message) |=> !in_message_reg)
        else $error("message still open after end of message");

    // Every rendered pattern is 12 to 16 modules
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_module_count >= 5'd12 && m_module_count <= 5'd16))
        else $error("module count out of range");

    // Stop is always the final pattern of its request
    a_stop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pattern_kind == KIND_STOP) |-> m_last)
        else $error("stop pattern not marked last");

    // A stalled output keeps the pending patterns untouched
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_any && m_valid && !m_ready) |=>
            ($stable(st_start_reg) && $stable(st_data_reg) && $stable(st_stop_reg)))
        else $error("pending patterns changed during stall");

endmodule

FILE: tb/sv/tb_code39_module_encoder.sv
`timescale 1ns / 1ps

// Top-level bench for the Code 39 module encoder.
module tb_code39_module_encoder;
    import c39enc_pkg::*;

    // Cycles to let a zero-result request clear the pipe before a ratio write
    localparam int DRAIN_CYCLES = 8;
    // Long output stall used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 300;

    // Wide-element masks per symbol, bit (8 - i) set when element i is wide.
    // Order: 0-9, A-Z, then - . $ / + % space.
    localparam logic [8:0] CHAR_WIDE [0:42] = '{
        9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
        9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
        9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
        9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
        9'h085, 9'h184, 9'h0A8, 9'h0A2, 9'h08A, 9'h02A, 9'h0C4
    };
    localparam logic [8:0] GUARD_WIDE = 9'h094;   // start/stop character
    localparam logic [7:0] PUNCT_CHARS [0:6] = '{"-", ".", "$", "/", "+", "%", " "};

    // Opening requests: one-char message, every letter case and digit edge,
    // all punctuation, invalid codes mid-message (no result), invalid code
    // closing a message (stop only), invalid code opening one (start only),
    // invalid code opening and closing (start and stop).
    localparam logic [7:0] OPEN_CHARS [0:21] = '{
        "0", "A", "Z", "a", "z", "9", "-", ".", "$", "/", "+",
        "%", " ", 8'h00, 8'hFF, "*", 8'hC1, 8'h7F, "@", "m", "[", "q"
    };
    localparam bit OPEN_EOM [0:21] = '{
        1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1
    };

    typedef struct packed {
        logic [15:0] modules;
        logic [4:0]  count;
        kind_t       kind;
        logic        last;
    } pattern_exp_t;

    // Predicts the patterns a request produces and matches them on output
    class pattern_tracker;
        pattern_exp_t pending_patterns[$];
        bit           msg_open;
        bit [1:0]     ratio;
        int unsigned  fail_count;

        function new();
            msg_open   = 0;
            ratio      = 2'd3;
            fail_count = 0;
        endfunction

        function void set_ratio(bit [1:0] value);
            ratio = value;
        endfunction

        function int pending();
            return pending_patterns.size();
        endfunction

        function pattern_exp_t render(logic [8:0] mask, bit gap, kind_t kind);
            pattern_exp_t p;
            int           span_wide;
            int           span;
            int           cnt;
            logic [31:0]  bits;
            span_wide = (ratio < 2) ? 2 : ratio;
            bits = '0;
            cnt  = 0;
            for (int i = 0; i < 9; i++) begin
                span = mask[8 - i] ? span_wide : 1;
                for (int j = 0; j < span; j++) begin
                    bits = {bits[30:0], (i % 2 == 0)};
                    cnt++;
                end
            end
            if (gap) begin
                bits = bits << 1;
                cnt++;
            end
            bits = bits << (16 - cnt);
            p.modules = bits[15:0];
            p.count   = cnt[4:0];
            p.kind    = kind;
            p.last    = 1'b0;
            return p;
        endfunction

        // Accepted request: queue up its patterns, returns how many
        function int take_char(logic [7:0] c, logic eom);
            pattern_exp_t batch[$];
            int           sym;
            sym = -1;
            if (c >= "0" && c <= "9")
                sym = c - "0";
            else if (c >= "A" && c <= "Z")
                sym = c - "A" + 10;
            else if (c >= "a" && c <= "z")
                sym = c - "a" + 10;
            else
                for (int k = 0; k < 7; k++)
                    if (c == PUNCT_CHARS[k])
                        sym = 36 + k;
            if (!msg_open) begin
                batch.push_back(render(GUARD_WIDE, 1'b1, KIND_START));
                msg_open = 1;
            end
            if (sym >= 0)
                batch.push_back(render(CHAR_WIDE[sym], 1'b1, KIND_DATA));
            if (eom) begin
                batch.push_back(render(GUARD_WIDE, 1'b0, KIND_STOP));
                msg_open = 0;
            end
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                pending_patterns.push_back(batch[k]);
            return batch.size();
        endfunction

        function void match_pattern(logic [15:0] modules, logic [4:0] count,
                                    logic [1:0] kind, logic last);
            pattern_exp_t e;
            if (pending_patterns.size() == 0) begin
                $error("unexpected pattern: modules %h count %0d kind %0d last %0d",
                       modules, count, kind, last);
                fail_count++;
                return;
            end
            e = pending_patterns.pop_front();
            if (modules !== e.modules) begin
                $error("modules: expected %h, got %h", e.modules, modules);
                fail_count++;
            end
            if (count !== e.count) begin
                $error("module_count: expected %0d, got %0d", e.count, count);
                fail_count++;
            end
            if (kind !== e.kind) begin
                $error("pattern_kind: expected %0d, got %0d", e.kind, kind);
                fail_count++;
            end
            if (last !== e.last) begin
                $error("last: expected %0d, got %0d", e.last, last);
                fail_count++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_wr_data;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_char_code;
    logic        s_end_of_message;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_modules;
    logic [4:0]  m_module_count;
    logic [1:0]  m_pattern_kind;
    logic        m_last;

    // Idle limits per side, changed between phases by the main sequence
    int tx_gap_max = 12;
    int rx_gap_max = 12;
    // One-shot output stall request, consumed by the sink process
    int rx_hold_cycles = 0;

    pattern_tracker tracker = new();

    code39_module_encoder uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_char_code      (s_char_code),
        .s_end_of_message (s_end_of_message),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_modules        (m_modules),
        .m_module_count   (m_module_count),
        .m_pattern_kind   (m_pattern_kind),
        .m_last           (m_last)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hard stop in case the pipe hangs
    initial begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Offer one request; entered and left at a falling edge.
    // Valid is only lowered when an idle gap is drawn, so back-to-back
    // requests keep valid high with a single assignment per step.
    task automatic send_char(input logic [7:0] c, input logic eom, output int produced);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_char_code      <= c;
        s_end_of_message <= eom;
        do @(posedge aclk); while (!s_ready);
        produced = tracker.take_char(c, eom);
        @(negedge aclk);
    endtask

    // Mostly legal characters in either case, the rest any byte at all
    function automatic logic [7:0] pick_char();
        int k;
        if ($urandom_range(0, 99) >= 80)
            return 8'($urandom_range(0, 255));
        k = $urandom_range(0, 42);
        if (k < 10)
            return 8'("0" + k);
        if (k < 36)
            return 8'(($urandom_range(0, 1) ? "a" : "A") + (k - 10));
        return PUNCT_CHARS[k - 36];
    endfunction

    // Random traffic until 'target' requests have produced some pattern.
    // Mostly complete messages; the rest lone requests with a random flag.
    task automatic run_traffic(input int target);
        int served;
        int len;
        int n;
        served = 0;
        while (served < target) begin
            if ($urandom_range(0, 99) < 80) begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    send_char(pick_char(), (i == len - 1), n);
                    if (n > 0) served++;
                end
            end else begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), n);
                if (n > 0) served++;
            end
        end
    endtask

    // Stop offering, wait for every pattern, then let any request that
    // makes no pattern clear the pipe
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Ratio write, block idle
    task automatic write_ratio(input logic [1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        tracker.set_ratio(value);
    endtask

    // Output side: random stall per pattern, plus the one long hold-off
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge aclk);
                rx_hold_cycles = 0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            tracker.match_pattern(m_modules, m_module_count, m_pattern_kind, m_last);
            @(negedge aclk);
        end
    end

    // Main sequence
    initial begin
        int n;
        aresetn          = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = 2'd0;
        s_valid          = 1'b0;
        s_char_code      = 8'd0;
        s_end_of_message = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset ratio of 3, directed requests
        foreach (OPEN_CHARS[i])
            send_char(OPEN_CHARS[i], OPEN_EOM[i], n);
        wait_idle();

        // Narrowest real ratio, full random idling
        write_ratio(2'd2);
        run_traffic(110);
        wait_idle();

        // Ratio 0 acts as 2; no idling on either side
        write_ratio(2'd0);
        tx_gap_max = 0;
        rx_gap_max = 0;
        run_traffic(80);
        wait_idle();

        // Ratio 1 acts as 2; output held off while input keeps coming
        write_ratio(2'd1);
        rx_hold_cycles = HOLD_OFF_CYCLES;
        rx_gap_max     = 12;
        run_traffic(60);
        wait_idle();

        // Back to the widest ratio, random idling
        write_ratio(2'd3);
        tx_gap_max = 12;
        run_traffic(170);
        wait_idle();

        if (tracker.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
